// ===== sv/ffha_pkg.sv =====
// Shared types and defaults of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

    localparam int DEF_MAX_CHUNKS   = 64;
    localparam int DEF_HEAP_BYTES   = 65536;
    localparam int DEF_HEADER_BYTES = 12;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NULL       = 3'd1,
        ST_HEAP_FULL  = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_BAD_FREE   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD  = 3'd0,
        OP_ROT   = 3'd1,
        OP_WRITE = 3'd2,
        OP_INS   = 3'd3,
        OP_DEL   = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     used;
        logic     start_en;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/ffha_cell.sv =====
// One chunk-table cell: start offset and used mark, linked to its ring neighbours.
`default_nettype none
module ffha_cell #(
    parameter int SW = 17,
    parameter int IW = 6,
    parameter int K  = 0
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ffha_pkg::cell_ctrl_t ctrl,
    input  wire  [IW-1:0]        idx,
    input  wire  [SW-1:0]        w_start,
    input  wire  [SW-1:0]        prv_start,
    input  wire                  prv_used,
    input  wire  [SW-1:0]        nxt_start,
    input  wire                  nxt_used,
    output logic [SW-1:0]        start,
    output logic                 used
);

    localparam logic [IW-1:0] MY_IDX = IW'(K);

    logic [SW-1:0] start_reg, start_next;
    logic          used_reg, used_next;

    always_comb
    begin
        start_next = start_reg;
        used_next  = used_reg;
        unique case (ctrl.op)
            ffha_pkg::OP_HOLD:
            begin
            end
            ffha_pkg::OP_ROT:
            begin
                start_next = nxt_start;
                used_next  = nxt_used;
            end
            ffha_pkg::OP_WRITE:
            begin
                if (MY_IDX == idx)
                begin
                    used_next = ctrl.used;
                    if (ctrl.start_en)
                        start_next = w_start;
                end
            end
            ffha_pkg::OP_INS:
            begin
                if (MY_IDX > idx)
                begin
                    start_next = prv_start;
                    used_next  = prv_used;
                end
                else if (MY_IDX == idx)
                begin
                    start_next = w_start;
                    used_next  = 1'b0;
                end
            end
            ffha_pkg::OP_DEL:
            begin
                if (MY_IDX >= idx)
                begin
                    start_next = nxt_start;
                    used_next  = nxt_used;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            used_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            used_reg  <= used_next;
        end
    end

    assign start = start_reg;
    assign used  = used_reg;

endmodule
`default_nettype wire

// ===== sv/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator: controller and ring of chunk cells.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid/in_ready, operation, alloc_size, | into block
//          | free_address                             |
//  out     | out_valid/out_ready, address, status     | out of block
//  cfg     | cfg_valid/cfg_ready, cfg_data (heap_base)| into block
//
// An item is latched, then the cell ring is rotated once past the head cell (the
// search), then the block decides, then the table edit applies its write, insert or delete beats.
// Reset leaves one free tail chunk at offset 0 and heap_base 0.
// A result that is not taken holds the block in its decide step; the next beat
// is taken once the edit is done, while the last result may still wait.
`default_nettype none
module first_fit_heap_allocator_top #(
    parameter int MAX_CHUNKS   = ffha_pkg::DEF_MAX_CHUNKS,
    parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         operation,
    input  wire  [16:0] alloc_size,
    input  wire  [31:0] free_address,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [31:0] address,
    output logic [2:0]  status,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [31:0] cfg_data
);

    localparam int SW = $clog2(HEAP_BYTES + 1);     // chunk offset width
    localparam int IW = $clog2(MAX_CHUNKS);         // table index width
    localparam int CW = $clog2(MAX_CHUNKS + 1);     // chunk count width
    localparam int XW = ((SW > 17) ? SW : 17) + 2;  // offset + size sums

    localparam logic [XW-1:0] HDR    = XW'(HEADER_BYTES);
    localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);
    localparam logic [CW-1:0] FULL   = CW'(MAX_CHUNKS);
    localparam logic [IW-1:0] LAST   = IW'(MAX_CHUNKS - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_DECIDE = 5'b00100,
        S_EXEC   = 5'b01000,
        S_SPARE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // heap base register
    logic [31:0] base_reg;

    // latched request
    logic        op_reg;
    logic [16:0] size_reg;
    logic [31:0] faddr_reg;

    // search bookkeeping
    logic [IW-1:0] cnt_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          prev_used_reg;
    logic          found_reg;
    logic [IW-1:0] fi_reg;
    logic [SW-1:0] f_start_reg, f_next_reg, tail_reg;
    logic          f_nused_reg, f_pused_reg, f_big_reg;

    // edit plan: three beats into the ring
    ffha_pkg::cell_ctrl_t plan_ctrl_reg [3];
    ffha_pkg::cell_ctrl_t plan_ctrl_next [3];
    logic [IW-1:0]        plan_idx_reg [3];
    logic [IW-1:0]        plan_idx_next [3];
    logic [SW-1:0]        plan_start_reg [3];
    logic [SW-1:0]        plan_start_next [3];
    logic [1:0]           slot_reg;

    // result
    logic        out_valid_reg;
    logic [31:0] addr_reg, addr_next;
    logic [2:0]  status_reg;
    ffha_pkg::status_t status_next;

    // ring
    logic [SW-1:0] cell_start [MAX_CHUNKS];
    logic          cell_used  [MAX_CHUNKS];
    ffha_pkg::cell_ctrl_t ring_ctrl;
    logic [IW-1:0] ring_idx;
    logic [SW-1:0] ring_wstart;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    wire in_fire  = in_valid && in_ready;
    wire commit   = (state_reg == S_DECIDE) && (!out_valid_reg || out_ready);

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign address   = addr_reg;
    assign status    = status_reg;

    // ---------------------------------------------------------------
    // Head-of-ring view during the search: cell 0 is logical entry cnt,
    // cell 1 is entry cnt+1.
    // ---------------------------------------------------------------
    logic [CW-1:0] cnt_x;
    logic          pair_ok, at_tail;
    logic [XW-1:0] size_x, s0_x, s1_x, span, need;
    logic          fit, big;
    logic [31:0]   off;
    logic          alloc_hit, free_hit;

    always_comb
    begin
        cnt_x     = CW'(cnt_reg);
        pair_ok   = (cnt_x + CW'(1)) < count_reg;
        at_tail   = cnt_x == (count_reg - CW'(1));
        size_x    = XW'(size_reg);
        s0_x      = XW'(cell_start[0]);
        s1_x      = XW'(cell_start[1]);
        span      = s1_x - s0_x;
        need      = HDR + size_x;
        fit       = span >= need;
        big       = span > (need + HDR);
        off       = faddr_reg - base_reg - 32'(HEADER_BYTES);
        alloc_hit = pair_ok && !cell_used[0] && fit;
        free_hit  = pair_ok && cell_used[0] && (32'(cell_start[0]) == off);
    end

    // ---------------------------------------------------------------
    // Decision after the search
    // ---------------------------------------------------------------
    logic [XW-1:0] tail_need;

    always_comb
    begin
        for (int s = 0; s < 3; s++)
        begin
            plan_ctrl_next[s]  = '{op: ffha_pkg::OP_HOLD, used: 1'b0, start_en: 1'b0};
            plan_idx_next[s]   = '0;
            plan_start_next[s] = '0;
        end
        count_next  = count_reg;
        addr_next   = '0;
        status_next = ffha_pkg::ST_OK;
        tail_need   = XW'(tail_reg) + HDR + HDR + size_x;

        if (!op_reg)
        begin
            priority if (size_reg == '0 || base_reg == '0)
                status_next = ffha_pkg::ST_NULL;
            else if (found_reg)
            begin
                if (f_big_reg && f_nused_reg && count_reg == FULL)
                    status_next = ffha_pkg::ST_TABLE_FULL;
                else
                begin
                    plan_ctrl_next[0] = '{op: ffha_pkg::OP_WRITE, used: 1'b1, start_en: 1'b0};
                    plan_idx_next[0]  = fi_reg;
                    if (f_big_reg)
                    begin
                        plan_idx_next[1]   = fi_reg + IW'(1);
                        plan_start_next[1] = f_next_reg;
                        if (!f_nused_reg)
                            // rest merges forward into the next free chunk
                            plan_ctrl_next[1] = '{op: ffha_pkg::OP_WRITE, used: 1'b0,
                                                  start_en: 1'b1};
                        else
                        begin
                            plan_ctrl_next[1] = '{op: ffha_pkg::OP_INS, used: 1'b0,
                                                  start_en: 1'b1};
                            count_next = count_reg + CW'(1);
                        end
                    end
                    addr_next = base_reg + 32'(f_start_reg) + 32'(HEADER_BYTES);
                end
            end
            else if (tail_need > HEAP_X)
                status_next = ffha_pkg::ST_HEAP_FULL;
            else if (count_reg == FULL)
                status_next = ffha_pkg::ST_TABLE_FULL;
            else
            begin
                // carve from the tail
                plan_ctrl_next[0]  = '{op: ffha_pkg::OP_WRITE, used: 1'b1, start_en: 1'b0};
                plan_idx_next[0]   = IW'(count_reg - CW'(1));
                plan_ctrl_next[1]  = '{op: ffha_pkg::OP_WRITE, used: 1'b0, start_en: 1'b1};
                plan_idx_next[1]   = IW'(count_reg);
                plan_start_next[1] = SW'(XW'(tail_reg) + HDR + size_x);
                count_next = count_reg + CW'(1);
                addr_next  = base_reg + 32'(tail_reg) + 32'(HEADER_BYTES);
            end
        end
        else
        begin
            priority if (faddr_reg == '0)
                status_next = ffha_pkg::ST_OK;
            else if (base_reg == '0 || !found_reg)
                status_next = ffha_pkg::ST_BAD_FREE;
            else
            begin
                plan_ctrl_next[0] = '{op: ffha_pkg::OP_WRITE, used: 1'b0, start_en: 1'b0};
                plan_idx_next[0]  = fi_reg;
                if (!f_nused_reg)
                begin
                    plan_ctrl_next[1] = '{op: ffha_pkg::OP_DEL, used: 1'b0, start_en: 1'b0};
                    plan_idx_next[1]  = fi_reg + IW'(1);
                end
                if (fi_reg != '0 && !f_pused_reg)
                begin
                    plan_ctrl_next[2] = '{op: ffha_pkg::OP_DEL, used: 1'b0, start_en: 1'b0};
                    plan_idx_next[2]  = fi_reg;
                end
                count_next = count_reg - CW'(!f_nused_reg)
                             - CW'(fi_reg != '0 && !f_pused_reg);
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_fire) state_next = S_SEARCH;
            S_SEARCH: if (cnt_reg == LAST) state_next = S_DECIDE;
            S_DECIDE: if (commit) state_next = S_EXEC;
            S_EXEC:   if (slot_reg == 2'd2) state_next = S_IDLE;
            S_SPARE:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ring_ctrl   = '{op: ffha_pkg::OP_HOLD, used: 1'b0, start_en: 1'b0};
        ring_idx    = '0;
        ring_wstart = '0;
        if (state_reg == S_SEARCH)
            ring_ctrl.op = ffha_pkg::OP_ROT;
        else if (state_reg == S_EXEC && slot_reg != 2'd3)
        begin
            ring_ctrl   = plan_ctrl_reg[slot_reg];
            ring_idx    = plan_idx_reg[slot_reg];
            ring_wstart = plan_start_reg[slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= '0;
            count_reg     <= CW'(1);
            cnt_reg       <= '0;
            slot_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                base_reg <= cfg_data;
            if (in_fire)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (state_reg == S_SEARCH)
            begin
                cnt_reg <= cnt_reg + IW'(1);
                if (!found_reg && ((!op_reg && alloc_hit) || (op_reg && free_hit)))
                    found_reg <= 1'b1;
            end
            if (commit)
            begin
                count_reg     <= count_next;
                slot_reg      <= '0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (out_valid_reg && out_ready)
                    out_valid_reg <= 1'b0;
                if (state_reg == S_EXEC)
                    slot_reg <= slot_reg + 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= operation;
            size_reg  <= alloc_size;
            faddr_reg <= free_address;
        end
        if (state_reg == S_SEARCH)
        begin
            prev_used_reg <= cell_used[0];
            if (at_tail)
                tail_reg <= cell_start[0];
            if (!found_reg && ((!op_reg && alloc_hit) || (op_reg && free_hit)))
            begin
                fi_reg      <= cnt_reg;
                f_start_reg <= cell_start[0];
                f_nused_reg <= cell_used[1];
                f_pused_reg <= prev_used_reg;
                f_big_reg   <= big;
                f_next_reg  <= SW'(s0_x + need);
            end
        end
        if (commit)
        begin
            addr_reg   <= addr_next;
            status_reg <= status_next;
            for (int s = 0; s < 3; s++)
            begin
                plan_ctrl_reg[s]  <= plan_ctrl_next[s];
                plan_idx_reg[s]   <= plan_idx_next[s];
                plan_start_reg[s] <= plan_start_next[s];
            end
        end
    end

    // ---------------------------------------------------------------
    // Cell ring
    // ---------------------------------------------------------------
    for (genvar k = 0; k < MAX_CHUNKS; k++)
    begin : g_cell
        ffha_cell #(
            .SW (SW),
            .IW (IW),
            .K  (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ring_ctrl),
            .idx       (ring_idx),
            .w_start   (ring_wstart),
            .prv_start (cell_start[(k + MAX_CHUNKS - 1) % MAX_CHUNKS]),
            .prv_used  (cell_used[(k + MAX_CHUNKS - 1) % MAX_CHUNKS]),
            .nxt_start (cell_start[(k + 1) % MAX_CHUNKS]),
            .nxt_used  (cell_used[(k + 1) % MAX_CHUNKS]),
            .start     (cell_start[k]),
            .used      (cell_used[k])
        );
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg <= FULL)
        else $error("chunk count out of range");

    a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_SEARCH && cnt_reg == '0)
        else $error("accepted beat did not start a search");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(count_reg))
        else $error("chunk count moved outside decide");

    a_exec_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg && state_reg == S_EXEC && slot_reg == 2'd0)
        else $error("commit did not post result and start edit");

endmodule
`default_nettype wire
